FILE: src/aaec_pkg.sv
`default_nettype none

package aaec_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int LIM_W      = 10;
    localparam int POS_W      = 12;
    localparam int FV_W       = 16;
    localparam int FILT_W     = 11;
    localparam int LIMIT_AXES = 2;

    // ewma held scaled by 40, new weight 10 out of 40
    localparam int EWMA_SCALE = 40;
    localparam int EWMA_HALF  = EWMA_SCALE / 2;

    // serial divider: dividend covers 1023 * 4095, divisor covers a 10-bit span
    localparam int DIV_DW = 22;
    localparam int DIV_VW = 10;

    localparam int CFG_AW = 4;
    localparam int APB_DW = 32;

    typedef logic [LIM_W-1:0] t_lim;

    typedef struct packed {
        t_lim [LIMIT_AXES-1:0] low;
        t_lim [LIMIT_AXES-1:0] high;
    } t_limits;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: src/aaec_div.sv
`default_nettype none

module aaec_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  aaec_pkg::t_div_req i_req,
    output aaec_pkg::t_div_rsp o_rsp
);
    import aaec_pkg::*;

    localparam int CNT_W = $clog2(DIV_DW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;

    logic [DIV_VW:0]   rem_sh;
    logic              fits;

    // one quotient bit per cycle, restoring form
    assign rem_sh = {r_rem, r_quo[DIV_DW-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_DW - 1);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DIV_VW'(rem_sh - {1'b0, r_dvs});
                end else begin
                    r_rem <= rem_sh[DIV_VW-1:0];
                end
                r_quo <= {r_quo[DIV_DW-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

FILE: src/aaec_cfg.sv
`default_nettype none

module aaec_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [aaec_pkg::CFG_AW-1:0]   paddr,
    input  wire [aaec_pkg::APB_DW-1:0]   pwdata,
    output logic [aaec_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output aaec_pkg::t_limits            o_limits
);
    import aaec_pkg::*;

    typedef enum logic [1:0] {
        REG_LOW0,
        REG_HIGH0,
        REG_LOW1,
        REG_HIGH1
    } t_reg_idx;

    t_reg_idx reg_idx;
    t_limits  r_lim;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.low[0]  <= '0;
            r_lim.high[0] <= '1;
            r_lim.low[1]  <= '0;
            r_lim.high[1] <= '1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOW0:  r_lim.low[0]  <= pwdata[LIM_W-1:0];
                REG_HIGH0: r_lim.high[0] <= pwdata[LIM_W-1:0];
                REG_LOW1:  r_lim.low[1]  <= pwdata[LIM_W-1:0];
                REG_HIGH1: r_lim.high[1] <= pwdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOW0:  prdata = APB_DW'(r_lim.low[0]);
            REG_HIGH0: prdata = APB_DW'(r_lim.high[0]);
            REG_LOW1:  prdata = APB_DW'(r_lim.low[1]);
            REG_HIGH1: prdata = APB_DW'(r_lim.high[1]);
            default:   prdata = '0;
        endcase
    end

    assign o_limits = r_lim;

endmodule

`default_nettype wire

FILE: src/axis_average_ewma_calibrate.sv
// axis_average_ewma_calibrate: per-axis averaging, ewma smoothing and range mapping
//
// s_axis carries one 10-bit converter reading per transfer (tdata) with its axis
// number in tuser. every SAMPLES_PER_AVG readings of one axis give one m_axis
// transfer: 12-bit mapped position in tdata, axis number in tuser. readings for
// an axis at or above NUM_AXES are taken and dropped.
// an apb port holds the low/high calibration limits of axes zero and one.
// flow: a reading that does not close an average is taken while s_axis_tready
// stays high. the reading that closes an average runs through one shared serial
// divider up to four times (sum / count, ewma decay, rounding by 40, range map);
// the first average of an axis skips the decay and an empty window skips the map.
// s_axis_tready is low from the closing reading until the result enters the
// output register, including any wait for it, so no reading is taken meanwhile.
// reset clears all sums, counts and filter states and loads the full-range limits;
// no clearing pass is needed afterwards.
// when m_axis_tready is low the result waits in the output register; the block
// keeps taking readings and only holds when a second result is ready to go out.
`default_nettype none

module axis_average_ewma_calibrate #(
    parameter int NUM_AXES        = 2,
    parameter int SAMPLES_PER_AVG = 6
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // apb configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [aaec_pkg::CFG_AW-1:0]   paddr,
    input  wire [aaec_pkg::APB_DW-1:0]   pwdata,
    output logic [aaec_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // reading stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [15:0]                   s_axis_tdata,  // [9:0] sample
    input  wire [0:0]                    s_axis_tuser,  // [0] axis_sel
    // position stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [15:0]                  m_axis_tdata,  // [11:0] position
    output logic [0:0]                   m_axis_tuser   // [0] axis_out
);
    import aaec_pkg::*;

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int SW  = SAMPLE_W + $clog2(SAMPLES_PER_AVG);
    localparam int CW  = $clog2(SAMPLES_PER_AVG + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_EWMA,
        S_ROUND,
        S_MAP,
        S_EMIT
    } t_state;

    t_state r_state;

    // per-axis state
    logic [SW-1:0]   r_sum    [NUM_AXES];
    logic [CW-1:0]   r_cnt    [NUM_AXES];
    logic [FV_W-1:0] r_fv     [NUM_AXES];
    logic            r_primed [NUM_AXES];

    // item in flight
    logic                r_ax;
    logic [SAMPLE_W-1:0] r_avg;
    logic [POS_W-1:0]    r_pos;

    // output register
    logic             r_out_valid;
    logic             r_out_ax;
    logic [POS_W-1:0] r_out_pos;

    t_limits  limits;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                in_fire;
    logic                ax_ok;
    logic [AXW-1:0]      in_idx;
    logic [AXW-1:0]      r_idx;
    logic [SW-1:0]       n_sum;
    logic [CW-1:0]       n_cnt;
    logic                avg_done;

    logic [SAMPLE_W-1:0] avg_q;
    logic [FV_W-1:0]     fv_cur;
    logic [FV_W-1:0]     n_fv_load;
    logic [FV_W-1:0]     n_fv_ewma;
    logic [FILT_W-1:0]   filt_q;
    t_lim                lo;
    t_lim                hi;
    logic                win_ok;
    logic [FILT_W-1:0]   clamped;
    logic [LIM_W-1:0]    offs;

    aaec_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    aaec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign ax_ok         = (32'(s_axis_tuser[0]) < NUM_AXES);
    assign in_idx        = AXW'(s_axis_tuser[0]);
    assign r_idx         = AXW'(r_ax);

    // accumulation of the incoming reading
    assign n_sum    = r_sum[in_idx] + SW'(s_axis_tdata[SAMPLE_W-1:0]);
    assign n_cnt    = r_cnt[in_idx] + 1'b1;
    assign avg_done = (n_cnt == CW'(SAMPLES_PER_AVG));

    // filter arithmetic, shift-and-add only
    assign avg_q     = div_rsp.quotient[SAMPLE_W-1:0];
    assign fv_cur    = r_fv[r_idx];
    assign n_fv_load = (FV_W'(avg_q) << 5) + (FV_W'(avg_q) << 3);
    // wraps at 16 bits like the filter state itself
    assign n_fv_ewma = (FV_W'(r_avg) << 3) + (FV_W'(r_avg) << 1)
                     + div_rsp.quotient[FV_W-1:0];

    // clamp to the calibration window
    assign filt_q = div_rsp.quotient[FILT_W-1:0];
    assign lo     = limits.low[r_ax];
    assign hi     = limits.high[r_ax];
    assign win_ok = (hi > lo);

    always_comb begin
        if (filt_q < FILT_W'(lo)) begin
            clamped = FILT_W'(lo);
        end else if (filt_q > FILT_W'(hi)) begin
            clamped = FILT_W'(hi);
        end else begin
            clamped = filt_q;
        end
    end

    assign offs = LIM_W'(clamped - FILT_W'(lo));

    // divider requests from the sequencer
    always_comb begin
        div_req = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire && ax_ok && avg_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_DW'(n_sum);
                    div_req.divisor  = DIV_VW'(SAMPLES_PER_AVG);
                end
            end
            S_AVG: begin
                if (div_rsp.done) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = DIV_VW'(EWMA_SCALE);
                    if (r_primed[r_idx]) begin
                        // 30 * old
                        div_req.dividend = (DIV_DW'(fv_cur) << 5) - (DIV_DW'(fv_cur) << 1);
                    end else begin
                        div_req.dividend = DIV_DW'(n_fv_load) + DIV_DW'(EWMA_HALF);
                    end
                end
            end
            S_EWMA: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.divisor  = DIV_VW'(EWMA_SCALE);
                    div_req.dividend = DIV_DW'(n_fv_ewma) + DIV_DW'(EWMA_HALF);
                end
            end
            S_ROUND: begin
                if (div_rsp.done && win_ok) begin
                    div_req.start    = 1'b1;
                    div_req.divisor  = DIV_VW'(hi - lo);
                    // offset * 4095
                    div_req.dividend = (DIV_DW'(offs) << POS_W) - DIV_DW'(offs);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sum[k]    <= '0;
                r_cnt[k]    <= '0;
                r_fv[k]     <= '0;
                r_primed[k] <= 1'b0;
            end
        end else begin
            // in S_EMIT the output register is reloaded or kept below
            if (m_axis_tvalid && m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire && ax_ok) begin
                        if (avg_done) begin
                            r_sum[in_idx] <= '0;
                            r_cnt[in_idx] <= '0;
                            r_ax          <= s_axis_tuser[0];
                            r_state       <= S_AVG;
                        end else begin
                            r_sum[in_idx] <= n_sum;
                            r_cnt[in_idx] <= n_cnt;
                        end
                    end
                end
                S_AVG: begin
                    if (div_rsp.done) begin
                        r_avg <= avg_q;
                        if (r_primed[r_idx]) begin
                            r_state <= S_EWMA;
                        end else begin
                            r_fv[r_idx]     <= n_fv_load;
                            r_primed[r_idx] <= 1'b1;
                            r_state         <= S_ROUND;
                        end
                    end
                end
                S_EWMA: begin
                    if (div_rsp.done) begin
                        r_fv[r_idx] <= n_fv_ewma;
                        r_state     <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (div_rsp.done) begin
                        if (win_ok) begin
                            r_state <= S_MAP;
                        end else begin
                            // empty window maps to zero
                            r_pos   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_MAP: begin
                    if (div_rsp.done) begin
                        r_pos   <= div_rsp.quotient[POS_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_ax    <= r_ax;
                        r_out_pos   <= r_pos;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_pos);
    assign m_axis_tuser  = r_out_ax;

endmodule

`default_nettype wire
